// ===== hdl/mcg_pkg.sv =====
// Shared constants, tables and types for the month calendar grid generator.
package mcg_pkg;

	localparam int unsigned YEAR_W = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W = 5;
	localparam int unsigned WDAY_W = 3;
	localparam int unsigned CELL_W = 6;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [WDAY_W-1:0] WDAY_SUN = 3'd7;
	localparam logic [WDAY_W-1:0] RSW_RESET = 3'd1;

	// x/25 = (x * 1311) >> 15 for x below 4096
	localparam logic [10:0] DIV25_MUL = 11'd1311;
	localparam int unsigned DIV25_SHIFT = 15;
	// x/7 = (x * 18725) >> 17 for x below 16384
	localparam logic [14:0] DIV7_MUL = 15'd18725;
	localparam int unsigned DIV7_SHIFT = 17;

	localparam logic [CELL_W-1:0] ROWS4_CELLS = 6'd28;
	localparam logic [CELL_W-1:0] ROWS5_CELLS = 6'd35;
	localparam logic [CELL_W-1:0] ROWS6_CELLS = 6'd42;

	typedef struct packed {
		logic                bad;
		logic [DAY_W-1:0]    len;
		logic [WDAY_W-1:0]   fw;
	} mcg_item_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] d;
		case (m)
			4'd2: d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	// days before the 1st of the month in a common year, modulo 7
	function automatic logic [WDAY_W-1:0] cum_mod7(input logic [MONTH_W-1:0] m);
		logic [WDAY_W-1:0] r;
		case (m)
			4'd2: r = 3'd3;
			4'd3: r = 3'd3;
			4'd4: r = 3'd6;
			4'd5: r = 3'd1;
			4'd6: r = 3'd4;
			4'd7: r = 3'd6;
			4'd8: r = 3'd2;
			4'd9: r = 3'd5;
			4'd10: r = 3'd0;
			4'd11: r = 3'd3;
			4'd12: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/month_calendar_grid_generator.sv =====
// Month calendar grid generator: date pipeline, cell sequencer and output register.
// A request passes the s1, s2, s3 and s4 registers, then the cell sequencer, then the output register.
// Throughput: one cell per cycle while out_stall is low; a request gives 28, 35 or 42 cells
// (1 on bad input), as chosen by the cell sequencer.
// The next request is taken while cells of the previous one are still being sent.
// Reset (arst_n low, asynchronous) empties the pipeline and sets the start weekday to Monday.
module month_calendar_grid_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcg_pkg::WDAY_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mcg_pkg::YEAR_W-1:0]    year,
	input  logic [mcg_pkg::MONTH_W-1:0]   month,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mcg_pkg::DAY_W-1:0]     cell_day,
	output logic [mcg_pkg::DAY_W-1:0]     month_length,
	output logic [mcg_pkg::WDAY_W-1:0]    first_weekday,
	output logic                          bad_input,
	output logic                          last_cell
);
	import mcg_pkg::*;

	logic [WDAY_W-1:0] rsw_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;

	logic               bad_s2;
	logic [YEAR_W-1:0]  p_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [22:0]        prod_s2;

	logic               bad_s3;
	logic               leap_s3;
	logic [MONTH_W-1:0] month_s3;
	logic [YEAR_W-1:0]  sum_s3;
	logic [27:0]        prod_s3;

	mcg_item_t item_s4;

	logic               gen_busy_q;
	logic [CELL_W-1:0]  cnt_q;
	logic [CELL_W-1:0]  cells_q;
	logic [2:0]         pad_q;
	mcg_item_t          gen_q;

	logic               out_valid_q;
	logic [DAY_W-1:0]   cell_day_q;
	logic [DAY_W-1:0]   len_q;
	logic [WDAY_W-1:0]  fw_q;
	logic               bad_q;
	logic               last_q;

	logic out_load, gen_last, gen_done, gen_take;

	// stage 1 -> 2: range check, y-1, first reciprocal multiply
	logic               bad_c1;
	logic [YEAR_W-1:0]  p_c1;
	logic [22:0]        prod_c1;

	// stage 2 -> 3: century count, leap, base day sum, mod 7 multiply
	logic [7:0]         cen_c2;
	logic [11:0]        q_c2;
	logic [14:0]        sum15_c2;
	logic [YEAR_W-1:0]  sum_c2;
	logic [YEAR_W-1:0]  rem100_c2;
	logic               leap_c2;
	logic [27:0]        prod_c2;

	// stage 3 -> 4: weekday of the 1st and month length
	logic [10:0]        quo_c3;
	logic [YEAR_W-1:0]  r14_c3;
	logic [3:0]         t_c3;
	logic [3:0]         tm_c3;
	logic               leapadj_c3;
	mcg_item_t          item_c3;

	// sequencer load: leading blanks and cell count
	logic [WDAY_W-1:0]  rs_c4;
	logic [3:0]         d_c4;
	logic [2:0]         pad_c4;
	logic [CELL_W-1:0]  ptot_c4;
	logic [CELL_W-1:0]  cells_c4;

	// current cell
	logic [CELL_W-1:0]  rel_c5;
	logic [DAY_W-1:0]   day_c5;

	assign out_load = gen_busy_q && (!out_valid_q || !out_stall);
	assign gen_last = (cnt_q == cells_q - 6'd1);
	assign gen_done = out_load && gen_last;
	assign gen_take = vld_s4 && (!gen_busy_q || gen_done);

	assign adv_s4 = gen_take;
	assign adv_s3 = vld_s3 && (!vld_s4 || adv_s4);
	assign adv_s2 = vld_s2 && (!vld_s3 || adv_s3);
	assign adv_s1 = vld_s1 && (!vld_s2 || adv_s2);
	assign in_stall = vld_s1 && !adv_s1;

	always_comb begin
		bad_c1 = (year_s1 == '0) || (year_s1 > YEAR_MAX) ||
			(month_s1 == '0) || (month_s1 > MONTH_MAX);
		p_c1 = year_s1 - 14'd1;
		prod_c1 = 23'(p_c1[13:2]) * 23'(DIV25_MUL);
	end

	always_comb begin
		cen_c2 = prod_s2[22:DIV25_SHIFT];
		q_c2 = p_s2[13:2];
		sum15_c2 = {1'b0, p_s2} + 15'(q_c2) - 15'(cen_c2) + 15'(cen_c2[7:2]);
		sum_c2 = sum15_c2[13:0];
		rem100_c2 = p_s2 - (14'(cen_c2) * 14'd100);
		leap_c2 = (p_s2[1:0] == 2'b11) && ((rem100_c2 != 14'd99) || (cen_c2[1:0] == 2'b11));
		prod_c2 = 28'(sum_c2) * 28'(DIV7_MUL);
	end

	always_comb begin
		quo_c3 = prod_s3[27:DIV7_SHIFT];
		r14_c3 = sum_s3 - (14'(quo_c3) * 14'd7);
		leapadj_c3 = leap_s3 && (month_s3 > MONTH_FEB);
		t_c3 = 4'(r14_c3[2:0]) + 4'(cum_mod7(month_s3)) + 4'(leapadj_c3);
		tm_c3 = (t_c3 >= 4'd7) ? (t_c3 - 4'd7) : t_c3;
		item_c3.bad = bad_s3;
		item_c3.len = bad_s3 ? '0 : month_days(month_s3, leap_s3);
		item_c3.fw = bad_s3 ? '0 : (tm_c3[2:0] + 3'd1);
	end

	always_comb begin
		rs_c4 = (rsw_q == WDAY_SUN) ? '0 : rsw_q;
		d_c4 = {1'b0, item_s4.fw} + 4'd7 - {1'b0, rs_c4};
		if (d_c4 >= 4'd14) begin
			pad_c4 = '0;
		end else if (d_c4 >= 4'd7) begin
			pad_c4 = 3'(d_c4 - 4'd7);
		end else begin
			pad_c4 = d_c4[2:0];
		end
		ptot_c4 = 6'(pad_c4) + 6'(item_s4.len);
		if (item_s4.bad) begin
			cells_c4 = 6'd1;
		end else if (ptot_c4 <= ROWS4_CELLS) begin
			cells_c4 = ROWS4_CELLS;
		end else if (ptot_c4 <= ROWS5_CELLS) begin
			cells_c4 = ROWS5_CELLS;
		end else begin
			cells_c4 = ROWS6_CELLS;
		end
	end

	always_comb begin
		rel_c5 = cnt_q - 6'(pad_q);
		if (!gen_q.bad && (cnt_q >= 6'(pad_q)) && (rel_c5 < 6'(gen_q.len))) begin
			day_c5 = 5'(rel_c5 + 6'd1);
		end else begin
			day_c5 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsw_q <= RSW_RESET;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			gen_busy_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rsw_q <= cfg_wdata;
			end
			if (!vld_s1 || adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (!vld_s2 || adv_s2) begin
				vld_s2 <= adv_s1;
			end
			if (!vld_s3 || adv_s3) begin
				vld_s3 <= adv_s2;
			end
			if (!vld_s4 || adv_s4) begin
				vld_s4 <= adv_s3;
			end
			if (gen_take) begin
				gen_busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (gen_done) begin
				gen_busy_q <= 1'b0;
			end else if (out_load) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			year_s1 <= year;
			month_s1 <= month;
		end
		if (adv_s1) begin
			bad_s2 <= bad_c1;
			p_s2 <= p_c1;
			month_s2 <= month_s1;
			prod_s2 <= prod_c1;
		end
		if (adv_s2) begin
			bad_s3 <= bad_s2;
			leap_s3 <= leap_c2;
			month_s3 <= month_s2;
			sum_s3 <= sum_c2;
			prod_s3 <= prod_c2;
		end
		if (adv_s3) begin
			item_s4 <= item_c3;
		end
		if (gen_take) begin
			gen_q <= item_s4;
			pad_q <= item_s4.bad ? 3'd0 : pad_c4;
			cells_q <= cells_c4;
		end
		if (out_load) begin
			cell_day_q <= day_c5;
			len_q <= gen_q.len;
			fw_q <= gen_q.fw;
			bad_q <= gen_q.bad;
			last_q <= gen_last;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_day = cell_day_q;
	assign month_length = len_q;
	assign first_weekday = fw_q;
	assign bad_input = bad_q;
	assign last_cell = last_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		gen_busy_q |-> (cnt_q < cells_q))
		else $error("cell counter beyond cell count");

	a_good_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bad_input) |-> (first_weekday != 3'd0 && month_length >= 5'd28))
		else $error("valid request with empty weekday or short month");

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_input) |-> (last_cell && cell_day == 5'd0 && month_length == 5'd0))
		else $error("bad request not a single blank word");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_cell) |=> out_valid)
		else $error("gap inside a month grid");

	a_day_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cell_day <= month_length))
		else $error("day number beyond month length");

endmodule

// ===== bench/mcg_grid_checker.sv =====
// Month grid checker: predicts the cell words of each request and compares the output channel.
module mcg_grid_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mcg_pkg::WDAY_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [mcg_pkg::YEAR_W-1:0]   year,
	input  logic [mcg_pkg::MONTH_W-1:0]  month,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [mcg_pkg::DAY_W-1:0]    cell_day,
	input  logic [mcg_pkg::DAY_W-1:0]    month_length,
	input  logic [mcg_pkg::WDAY_W-1:0]   first_weekday,
	input  logic                         bad_input,
	input  logic                         last_cell,
	output int                           fails,
	output int                           pending
);
	import mcg_pkg::*;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [DAY_W-1:0]  len;
		logic [WDAY_W-1:0] fw;
		logic              bad;
		logic              last;
	} grid_word_t;

	grid_word_t cells_due[$];
	logic [WDAY_W-1:0] col0_wday = RSW_RESET;
	int n_bad = 0;
	int n_due = 0;

	assign fails = n_bad;
	assign pending = n_due;

	function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
		logic leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic void month_grid_cells(input logic [YEAR_W-1:0] y,
		input logic [MONTH_W-1:0] m);
		int unsigned p, total, len, fw, pad, ncells;
		grid_word_t w;
		if (y == 0 || y > YEAR_MAX || m == 0 || m > MONTH_MAX) begin
			w = '{day: '0, len: '0, fw: '0, bad: 1'b1, last: 1'b1};
			cells_due.push_back(w);
			return;
		end
		// days since 1 Jan of year 1, a Monday
		p = y - 1;
		total = 365 * p + p / 4 - p / 100 + p / 400;
		for (int unsigned i = 1; i < m; i++)
			total += days_in(y, i);
		fw = total % 7 + 1;
		len = days_in(y, m);
		// start weekday 0 behaves as Sunday
		pad = (fw + 7 - col0_wday % 7) % 7;
		ncells = (pad + len + 6) / 7 * 7;
		for (int unsigned c = 0; c < ncells; c++) begin
			w.day = (c >= pad && c - pad < len) ? DAY_W'(c - pad + 1) : '0;
			w.len = DAY_W'(len);
			w.fw = WDAY_W'(fw);
			w.bad = 1'b0;
			w.last = (c + 1 == ncells);
			cells_due.push_back(w);
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			n_bad++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grid_word_t want;
		if (!arst_n) begin
			col0_wday = RSW_RESET;
			cells_due.delete();
		end else begin
			if (cfg_we)
				col0_wday = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (cells_due.size() == 0) begin
					n_bad++;
					$error("cell word with none outstanding: day %0d", cell_day);
				end else begin
					want = cells_due.pop_front();
					check_field("cell_day", 8'(want.day), 8'(cell_day));
					check_field("month_length", 8'(want.len), 8'(month_length));
					check_field("first_weekday", 8'(want.fw), 8'(first_weekday));
					check_field("bad_input", 8'(want.bad), 8'(bad_input));
					check_field("last_cell", 8'(want.last), 8'(last_cell));
				end
			end
			if (in_valid && !in_stall)
				month_grid_cells(year, month);
		end
		n_due = cells_due.size();
	end

endmodule

// ===== bench/tb_month_calendar_grid_generator.sv =====
// Testbench top for the month calendar grid generator: stimulus, output stalls and verdict.
module tb_month_calendar_grid_generator;
	import mcg_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_REQS = 44;
	localparam int N_DIRECTED = 24;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [WDAY_W-1:0]   cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DAY_W-1:0]    cell_day;
	logic [DAY_W-1:0]    month_length;
	logic [WDAY_W-1:0]   first_weekday;
	logic                bad_input;
	logic                last_cell;
	int                  fails;
	int                  pending;

	logic calm = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int stall_left = 0;
	int stall_pct = 20;
	int gap_pct = 20;
	int n_sent = 0;
	int quiet_cycles = 0;

	logic [YEAR_W-1:0] dir_year[N_DIRECTED] = '{
		14'd1, 14'd9999, 14'd2024, 14'd2024, 14'd2024, 14'd2024, 14'd2024, 14'd2024,
		14'd2024, 14'd2024, 14'd2024, 14'd2024, 14'd2024, 14'd2024, 14'd2000, 14'd1900,
		14'd2023, 14'd2015, 14'd0, 14'd10000, 14'd16383, 14'd9999, 14'd1, 14'd8191};
	logic [MONTH_W-1:0] dir_month[N_DIRECTED] = '{
		4'd1, 4'd12, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
		4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd2, 4'd2,
		4'd2, 4'd2, 4'd1, 4'd6, 4'd15, 4'd0, 4'd13, 4'd12};
	logic [WDAY_W-1:0] phase_wday[8] = '{3'd7, 3'd0, 3'd1, 3'd3, 3'd6, 3'd2, 3'd5, 3'd4};

	month_calendar_grid_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.year(year),
		.month(month),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_day(cell_day),
		.month_length(month_length),
		.first_weekday(first_weekday),
		.bad_input(bad_input),
		.last_cell(last_cell)
	);

	mcg_grid_checker grid_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.year(year),
		.month(month),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_day(cell_day),
		.month_length(month_length),
		.first_weekday(first_weekday),
		.bad_input(bad_input),
		.last_cell(last_cell),
		.fails(fails),
		.pending(pending)
	);

	always #6 clk = ~clk;

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	// receiver: random stall bursts, one long hold-off on request
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			stall_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
		if ($urandom_range(0, 199) == 0)
			stall_pct <= pick_pct();
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_req(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		year <= y;
		month <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
		if (n_sent % 20 == 0)
			gap_pct = pick_pct();
	endtask

	task automatic send_random_req();
		int r;
		logic [YEAR_W-1:0] y;
		logic [MONTH_W-1:0] m;
		r = $urandom_range(0, 99);
		y = YEAR_W'($urandom_range(1, 9999));
		m = MONTH_W'($urandom_range(1, 12));
		if (r < 12) begin
			// century years, leap rule edges
			y = YEAR_W'($urandom_range(1, 99) * 100);
			if ($urandom_range(0, 1))
				m = MONTH_FEB;
		end else if (r < 84) begin
		end else if (r < 90) begin
			y = $urandom_range(0, 1) ? 14'd0 : YEAR_W'($urandom_range(10000, 16383));
		end else if (r < 96) begin
			m = $urandom_range(0, 1) ? 4'd0 : MONTH_W'($urandom_range(13, 15));
		end else begin
			y = YEAR_W'($urandom);
			m = MONTH_W'($urandom);
		end
		send_req(y, m);
	endtask

	// lower valid, wait for the grid to drain, then write the start weekday
	task automatic set_start_wday(input logic [WDAY_W-1:0] v);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		year <= '0;
		month <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_req(dir_year[i], dir_month[i]);

		for (int ph = 0; ph < 8; ph++) begin
			set_start_wday(phase_wday[ph]);
			if (ph == 2)
				hold_req <= 1'b1;
			if (ph == 7)
				calm <= 1'b1;
			for (int i = 0; i < PHASE_REQS; i++)
				send_random_req();
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== month_calendar_grid_generator.f =====
hdl/mcg_pkg.sv
hdl/month_calendar_grid_generator.sv
bench/mcg_grid_checker.sv
bench/tb_month_calendar_grid_generator.sv
